### design/pkbd_pkg.sv
// ----------------------------------------------------------------------------
// pkbd_pkg
// Shared types and constants of the planar PackBits image decoder.
// ----------------------------------------------------------------------------
package pkbd_pkg;

  localparam int PIX_W   = 25;
  localparam int ROW_W   = 15;
  localparam int CH_W    = 3;
  localparam int CFG_W   = 25;
  localparam int ADDR_W  = 26;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_PIXEL_COUNT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_COUNT     = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EARLY    = 2'd2;

  localparam logic [7:0] HDR_NOP = 8'd128;

  localparam int DEF_MAX_PIXEL_COUNT = 16777216;
  localparam int DEF_MAX_ROW_COUNT   = 16384;

  localparam logic [1:0] LANE_RGBA [4] = '{2'd2, 2'd1, 2'd0, 2'd3};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] len;      // run length of a header byte, 0 for the no-op code
    logic       literal;
  } pkbd_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixels;
    logic [ROW_W-1:0] rows;
    logic [CH_W-1:0]  channels;
  } pkbd_cfg_t;

endpackage

### design/packbits_planar_image_decoder.sv
// ----------------------------------------------------------------------------
// packbits_planar_image_decoder
// Planar PackBits decoder: skips the row byte-count table, decodes each
// channel plane and emits interleaved destination writes.
// ----------------------------------------------------------------------------
//  channel | handshake                      | payload
//  in      | in_valid / in_stall            | data_byte, end_of_data
//  out     | out_valid / out_stall          | byte_address, value, run_length,
//          |                                | image_done, status
//  cfg     | cfg_write                      | cfg_index, cfg_data
//
//  Sustained rate is one item per cycle unless the output stalls; a result
//  is registered as the engine takes its item. The decode engine's single
//  state update per cycle sets that rate. A two-entry queue between input
//  and engine keeps input flowing for two items while the output is stalled.
//  Reset is synchronous and returns the registers to their reset values.
// ----------------------------------------------------------------------------
module packbits_planar_image_decoder #(
  parameter int MAX_PIXEL_COUNT = pkbd_pkg::DEF_MAX_PIXEL_COUNT,
  parameter int MAX_ROW_COUNT   = pkbd_pkg::DEF_MAX_ROW_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pkbd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pkbd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pkbd_pkg::ADDR_W-1:0] byte_address,
  output logic [7:0]                  value,
  output logic [7:0]                  run_length,
  output logic                        image_done,
  output logic [1:0]                  status
);
  import pkbd_pkg::*;

  localparam logic [31:0] MAX_PIX  = 32'(MAX_PIXEL_COUNT);
  localparam logic [31:0] MAX_ROWS = 32'(MAX_ROW_COUNT);

  pkbd_cfg_t  cfg;
  pkbd_item_t item;
  logic       item_valid;
  logic       item_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixels   <= PIX_W'(1);
      cfg.rows     <= ROW_W'(1);
      cfg.channels <= CH_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_COUNT: begin
          if (cfg_data == '0) begin
            cfg.pixels <= PIX_W'(1);
          end else if ({7'd0, cfg_data} > MAX_PIX) begin
            cfg.pixels <= MAX_PIX[PIX_W-1:0];
          end else begin
            cfg.pixels <= cfg_data[PIX_W-1:0];
          end
        end
        REG_ROW_COUNT: begin
          if ({17'd0, cfg_data[ROW_W-1:0]} > MAX_ROWS) begin
            cfg.rows <= MAX_ROWS[ROW_W-1:0];
          end else begin
            cfg.rows <= cfg_data[ROW_W-1:0];
          end
        end
        REG_CHANNEL_COUNT: begin
          if (cfg_data[CH_W-1:0] == '0) begin
            cfg.channels <= CH_W'(1);
          end else if (cfg_data[CH_W-1:0] > CH_W'(4)) begin
            cfg.channels <= CH_W'(4);
          end else begin
            cfg.channels <= cfg_data[CH_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  pkbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  pkbd_back #(
    .MAX_ROW_COUNT (MAX_ROW_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_address (byte_address),
    .value        (value),
    .run_length   (run_length),
    .image_done   (image_done),
    .status       (status)
  );

  a_stall_needs_queued: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("input stalled with an empty queue");

  a_ok_has_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (run_length != 8'd0))
    else $error("ok item without a write");

  a_overflow_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OVERFLOW) |-> (run_length == 8'd0 && !image_done))
    else $error("overflow item carries a write");

  a_done_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_done) |-> (status == ST_OK && run_length != 8'd0))
    else $error("image done on a bad item");

endmodule

### design/pkbd_front.sv
// ----------------------------------------------------------------------------
// pkbd_front
// Accepts compressed bytes, decodes the header meaning of each one and
// queues the items for the decode engine.
// ----------------------------------------------------------------------------
module pkbd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                end_of_data,
  output logic                item_valid,
  output pkbd_pkg::pkbd_item_t item,
  input  logic                item_pop
);
  import pkbd_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pkbd_item_t            slots [DEPTH];
  pkbd_item_t            incoming;
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  push;
  logic                  pop;

  always_comb begin
    incoming.data    = data_byte;
    incoming.last    = end_of_data;
    incoming.literal = ~data_byte[7];
    if (data_byte == HDR_NOP) begin
      incoming.len = 8'd0;
    end else if (!data_byte[7]) begin
      incoming.len = data_byte + 8'd1;
    end else begin
      incoming.len = 8'(9'd257 - {1'b0, data_byte});
    end
  end

  assign in_stall   = (count == CNT_W'(DEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (count != '0);
  assign pop        = item_pop && item_valid;
  assign item       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### design/pkbd_back.sv
// ----------------------------------------------------------------------------
// pkbd_back
// Decode engine: skips the row table, runs the PackBits phases per plane,
// forms destination addresses and holds the result in an output register.
// ----------------------------------------------------------------------------
module pkbd_back #(
  parameter int MAX_ROW_COUNT = pkbd_pkg::DEF_MAX_ROW_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pkbd_pkg::pkbd_cfg_t        cfg,
  input  logic                       item_valid,
  input  pkbd_pkg::pkbd_item_t       item,
  output logic                       item_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pkbd_pkg::ADDR_W-1:0] byte_address,
  output logic [7:0]                 value,
  output logic [7:0]                 run_length,
  output logic                       image_done,
  output logic [1:0]                 status
);
  import pkbd_pkg::*;

  localparam int SKIP_W = $clog2(8 * MAX_ROW_COUNT + 1);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_SKIP  = 3'd1;
  localparam logic [2:0] PH_HEAD  = 3'd2;
  localparam logic [2:0] PH_LIT   = 3'd3;
  localparam logic [2:0] PH_REP   = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;
  localparam logic [2:0] PH_ERR   = 3'd6;

  logic [2:0]        phase, phase_next;
  logic [SKIP_W-1:0] skip_left, skip_left_next;
  logic [1:0]        plane_index, plane_index_next;
  logic [PIX_W-1:0]  pixels_done, pixels_done_next;
  logic [7:0]        literal_left, literal_left_next;
  logic [7:0]        repeat_length, repeat_length_next;

  logic              fire;
  logic              have;
  logic [ADDR_W-1:0] r_addr;
  logic [7:0]        r_val;
  logic [7:0]        r_run;
  logic              r_done;
  logic [1:0]        r_status;

  logic [31:0]       table_total;
  logic [SKIP_W-1:0] skip_total;
  logic [1:0]        bpp_shift;
  logic [1:0]        lane;
  logic [ADDR_W:0]   addr_wide;
  logic [ADDR_W-1:0] cur_addr;
  logic              last_plane;

  always_comb begin
    unique case (cfg.channels)
      3'd1:    table_total = {17'd0, cfg.rows};
      3'd2:    table_total = {16'd0, cfg.rows, 1'b0};
      3'd3:    table_total = {17'd0, cfg.rows} + {16'd0, cfg.rows, 1'b0};
      default: table_total = {15'd0, cfg.rows, 2'b0};
    endcase
  end
  assign skip_total = SKIP_W'({table_total[30:0], 1'b0});

  always_comb begin
    if (cfg.channels < 3'd3) begin
      bpp_shift = (cfg.channels == 3'd2) ? 2'd1 : 2'd0;
      lane      = {1'b0, plane_index[0]};
    end else begin
      bpp_shift = 2'd2;
      lane      = LANE_RGBA[plane_index];
    end
  end

  assign addr_wide  = ({2'b00, pixels_done} << bpp_shift) + (ADDR_W + 1)'(lane);
  assign cur_addr   = addr_wide[ADDR_W-1:0];
  assign last_plane = ({1'b0, plane_index} + 3'd1) >= cfg.channels;

  assign fire     = item_valid && (!out_valid || !out_stall);
  assign item_pop = fire;

  always_comb begin
    logic            consumed;
    logic [7:0]      adv_n;
    logic [PIX_W:0]  adv_sum;
    logic [PIX_W:0]  head_sum;
    phase_next         = phase;
    skip_left_next     = skip_left;
    plane_index_next   = plane_index;
    pixels_done_next   = pixels_done;
    literal_left_next  = literal_left;
    repeat_length_next = repeat_length;
    have     = 1'b0;
    r_addr   = '0;
    r_val    = '0;
    r_run    = '0;
    r_done   = 1'b0;
    r_status = ST_OK;
    consumed = 1'b0;
    adv_n    = (phase == PH_REP) ? repeat_length : 8'd1;
    adv_sum  = {1'b0, pixels_done} + (PIX_W + 1)'(adv_n);
    head_sum = {1'b0, pixels_done} + (PIX_W + 1)'(item.len);

    if (phase == PH_START) begin
      if (skip_total != '0) begin
        skip_left_next = skip_total - SKIP_W'(1);
        phase_next     = (skip_left_next != '0) ? PH_SKIP : PH_HEAD;
        consumed       = 1'b1;
      end else begin
        phase_next = PH_HEAD;
      end
    end

    if (!consumed) begin
      unique case (phase_next)
        PH_SKIP: begin
          if (skip_left != '0) begin
            skip_left_next = skip_left - SKIP_W'(1);
          end
          if (skip_left_next == '0) begin
            phase_next = PH_HEAD;
          end
        end
        PH_HEAD: begin
          if (item.len != 8'd0) begin
            if (head_sum > {1'b0, cfg.pixels}) begin
              have       = 1'b1;
              r_status   = ST_OVERFLOW;
              phase_next = PH_ERR;
            end else if (item.literal) begin
              literal_left_next = item.len;
              phase_next        = PH_LIT;
            end else begin
              repeat_length_next = item.len;
              phase_next         = PH_REP;
            end
          end
        end
        PH_LIT, PH_REP: begin
          have   = 1'b1;
          r_addr = cur_addr;
          r_val  = item.data;
          r_run  = adv_n;
          if (adv_sum >= {1'b0, cfg.pixels}) begin
            pixels_done_next = '0;
            if (last_plane) begin
              phase_next = PH_DONE;
              r_done     = 1'b1;
            end else begin
              plane_index_next = plane_index + 2'd1;
              phase_next       = PH_HEAD;
            end
          end else begin
            pixels_done_next = adv_sum[PIX_W-1:0];
          end
          if (phase == PH_LIT) begin
            if (literal_left != 8'd0) begin
              literal_left_next = literal_left - 8'd1;
            end
            if (phase_next == PH_LIT && literal_left_next == 8'd0) begin
              phase_next = PH_HEAD;
            end
            if (phase_next != PH_LIT) begin
              literal_left_next = 8'd0;
            end
          end else begin
            repeat_length_next = 8'd0;
            if (phase_next == PH_REP) begin
              phase_next = PH_HEAD;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (item.last) begin
      if (phase_next != PH_DONE && phase_next != PH_ERR) begin
        have     = 1'b1;
        r_status = ST_EARLY;
      end
      phase_next         = PH_START;
      skip_left_next     = '0;
      plane_index_next   = 2'd0;
      pixels_done_next   = '0;
      literal_left_next  = 8'd0;
      repeat_length_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      skip_left     <= '0;
      plane_index   <= 2'd0;
      pixels_done   <= '0;
      literal_left  <= 8'd0;
      repeat_length <= 8'd0;
    end else if (fire) begin
      phase         <= phase_next;
      skip_left     <= skip_left_next;
      plane_index   <= plane_index_next;
      pixels_done   <= pixels_done_next;
      literal_left  <= literal_left_next;
      repeat_length <= repeat_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && have) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && have) begin
      byte_address <= r_addr;
      value        <= r_val;
      run_length   <= r_run;
      image_done   <= r_done;
      status       <= r_status;
    end
  end

endmodule

### tb/sv/pkbd_write_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pkbd_write_checker
// Watches the config, input and output channels of the planar PackBits
// decoder. Keeps its own decoder state, works out the destination write that
// each accepted item should cause, and compares every accepted result with
// the oldest pending write.
// ----------------------------------------------------------------------------
module pkbd_write_checker
  import pkbd_pkg::*;
#(
  parameter int MAX_PIXEL_COUNT = DEF_MAX_PIXEL_COUNT,
  parameter int MAX_ROW_COUNT   = DEF_MAX_ROW_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ADDR_W-1:0] byte_address,
  input  logic [7:0]        value,
  input  logic [7:0]        run_length,
  input  logic              image_done,
  input  logic [1:0]        status,
  output int                fail_count,
  output int                pending,
  output int                writes_seen
);

  typedef enum logic [2:0] {
    DEC_START, DEC_SKIP, DEC_HEAD, DEC_LIT, DEC_REP, DEC_DONE, DEC_ERR
  } dec_phase_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        value;
    logic [7:0]        run;
    logic              done;
    logic [1:0]        status;
  } pixel_write_t;

  logic [PIX_W-1:0] pix_reg;
  logic [ROW_W-1:0] rows_reg;
  logic [CH_W-1:0]  chans_reg;

  dec_phase_e  dec_phase;
  int unsigned skip_left;
  logic [1:0]  plane_index;
  int unsigned pixels_done;
  int unsigned literal_left;
  int unsigned repeat_len;

  pixel_write_t expected_writes[$];

  function automatic int unsigned pixels_eff();
    if (pix_reg == 0) return 1;
    if (pix_reg > MAX_PIXEL_COUNT) return MAX_PIXEL_COUNT;
    return pix_reg;
  endfunction

  function automatic int unsigned chans_eff();
    if (chans_reg == 0) return 1;
    if (chans_reg > 4) return 4;
    return chans_reg;
  endfunction

  function automatic int unsigned rows_eff();
    return (rows_reg > MAX_ROW_COUNT) ? MAX_ROW_COUNT : rows_reg;
  endfunction

  function automatic void restart();
    dec_phase    = DEC_START;
    skip_left    = 0;
    plane_index  = 2'd0;
    pixels_done  = 0;
    literal_left = 0;
    repeat_len   = 0;
  endfunction

  function automatic logic [ADDR_W-1:0] dest_addr();
    int unsigned ch, bpp, lane;
    ch   = chans_eff();
    bpp  = (ch < 3) ? ch : 4;
    lane = (ch < 3) ? plane_index[0] : LANE_RGBA[plane_index];
    return ADDR_W'(pixels_done * bpp + lane);
  endfunction

  // advances the plane position; 1 when the last plane completes
  function automatic logic count_pixels(input int unsigned n);
    pixels_done += n;
    if (pixels_done >= pixels_eff()) begin
      pixels_done = 0;
      if (plane_index + 1 >= chans_eff()) begin
        dec_phase = DEC_DONE;
        return 1'b1;
      end
      plane_index++;
      dec_phase = DEC_HEAD;
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    pixel_write_t w;
    logic         have, consumed;
    int unsigned  len, total;
    w        = '0;
    have     = 1'b0;
    consumed = 1'b0;
    len      = 0;
    if (dec_phase == DEC_START) begin
      total = 2 * rows_eff() * chans_eff();
      if (total > 0) begin
        skip_left = total - 1;
        dec_phase = (skip_left != 0) ? DEC_SKIP : DEC_HEAD;
        consumed  = 1'b1;
      end else begin
        dec_phase = DEC_HEAD;
      end
    end
    if (!consumed) begin
      case (dec_phase)
        DEC_SKIP: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) dec_phase = DEC_HEAD;
        end
        DEC_HEAD: begin
          if (b < HDR_NOP) len = b + 1;
          else if (b > HDR_NOP) len = 257 - b;
          if (len != 0) begin
            if (pixels_done + len > pixels_eff()) begin
              have      = 1'b1;
              w.status  = ST_OVERFLOW;
              dec_phase = DEC_ERR;
            end else if (b < HDR_NOP) begin
              literal_left = len;
              dec_phase    = DEC_LIT;
            end else begin
              repeat_len = len;
              dec_phase  = DEC_REP;
            end
          end
        end
        DEC_LIT: begin
          have    = 1'b1;
          w.addr  = dest_addr();
          w.value = b;
          w.run   = 8'd1;
          if (literal_left > 0) literal_left--;
          w.done = count_pixels(1);
          if (dec_phase == DEC_LIT && literal_left == 0) dec_phase = DEC_HEAD;
          if (dec_phase != DEC_LIT) literal_left = 0;
        end
        DEC_REP: begin
          have    = 1'b1;
          w.addr  = dest_addr();
          w.value = b;
          w.run   = repeat_len[7:0];
          w.done  = count_pixels(repeat_len);
          repeat_len = 0;
          if (dec_phase == DEC_REP) dec_phase = DEC_HEAD;
        end
        default: ;
      endcase
    end
    if (last) begin
      if (dec_phase != DEC_DONE && dec_phase != DEC_ERR) begin
        have     = 1'b1;
        w.status = ST_EARLY;
      end
      restart();
    end
    if (have) expected_writes.push_back(w);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    pixel_write_t w;
    if (rst) begin
      pix_reg     = PIX_W'(1);
      rows_reg    = ROW_W'(1);
      chans_reg   = CH_W'(1);
      fail_count  = 0;
      writes_seen = 0;
      restart();
      expected_writes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        writes_seen++;
        if (expected_writes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got addr %0h value %0h run %0d",
                   $time, byte_address, value, run_length);
        end else begin
          w = expected_writes.pop_front();
          check_field("byte_address", w.addr, byte_address);
          check_field("value", w.value, value);
          check_field("run_length", w.run, run_length);
          check_field("image_done", w.done, image_done);
          check_field("status", w.status, status);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_PIXEL_COUNT:   pix_reg   = cfg_data[PIX_W-1:0];
          REG_ROW_COUNT:     rows_reg  = cfg_data[ROW_W-1:0];
          REG_CHANNEL_COUNT: chans_reg = cfg_data[CH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(data_byte, end_of_data);
    end
    pending = expected_writes.size();
  end

endmodule

### tb/sv/tb_packbits_planar_image_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packbits_planar_image_decoder
// Drives compressed data sections into the planar PackBits decoder: a short
// directed set, then randomized well-formed, truncated, overflowing and noisy
// sections over a range of register settings, with random idling on both
// channels, one long output hold and a gap-free tail. Checking is done by
// pkbd_write_checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_packbits_planar_image_decoder;
  import pkbd_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int BODY_CAP      = 400;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {SEC_WELL, SEC_EARLY, SEC_OVERFLOW, SEC_NOISE} sec_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stim_byte_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              end_of_data;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] byte_address;
  logic [7:0]        value;
  logic [7:0]        run_length;
  logic              image_done;
  logic [1:0]        status;

  int fail_count, pending, writes_seen;

  int          idle_pct;
  bit          calm;
  bit          hold_req;
  int          quiet_cycles;
  int          items_sent;
  int          settings_used;
  int          kind_count[4];
  int unsigned cfg_pix, cfg_rows, cfg_ch;
  stim_byte_t  section_q[$];

  always #5 clk = ~clk;

  packbits_planar_image_decoder u_dut (.*);

  pkbd_write_checker u_check (.*);

  // watchdog: cycles with no accepted item on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // output side: random stall bursts, one long hold on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = LONG_HOLD;
          hold_req   = 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
          stall_left = $urandom_range(1, 16);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void add(input logic [7:0] b, input logic last = 1'b0);
    section_q.push_back({b, last});
  endfunction

  task automatic send_item(input stim_byte_t it);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    data_byte   <= it.data;
    end_of_data <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_section();
    foreach (section_q[i]) send_item(section_q[i]);
    section_q.delete();
  endtask

  // input idle until every pending write is back and the block has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
  endtask

  task automatic set_config(input int unsigned pix, input int unsigned rows,
                            input int unsigned ch);
    write_reg(REG_PIXEL_COUNT, CFG_W'(pix));
    write_reg(REG_ROW_COUNT, CFG_W'(rows));
    write_reg(REG_CHANNEL_COUNT, CFG_W'(ch));
    @(negedge clk);
    cfg_write <= 1'b0;
    repeat (2) @(negedge clk);
    cfg_pix  = pix;
    cfg_rows = rows;
    cfg_ch   = ch;
    settings_used++;
  endtask

  task automatic random_config();
    set_config(($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40),
               $urandom_range(0, 3), $urandom_range(0, 7));
  endtask

  task automatic gen_section(input sec_kind_e kind);
    int unsigned npix, nch, nrows, tbl, remain, len, pick, cut, top;
    bit overflowed, capped;
    npix  = (cfg_pix == 0) ? 1 : ((cfg_pix > DEF_MAX_PIXEL_COUNT) ? DEF_MAX_PIXEL_COUNT : cfg_pix);
    nch   = (cfg_ch == 0) ? 1 : ((cfg_ch > 4) ? 4 : cfg_ch);
    nrows = (cfg_rows > DEF_MAX_ROW_COUNT) ? DEF_MAX_ROW_COUNT : cfg_rows;
    tbl   = 2 * nrows * nch;
    overflowed = 1'b0;
    capped     = 1'b0;
    kind_count[kind]++;
    if (kind == SEC_NOISE) begin
      repeat ($urandom_range(1, 24)) add(8'($urandom), $urandom_range(0, 7) == 0);
    end else begin
      repeat (tbl) add(8'($urandom));
      for (int p = 0; p < nch && !overflowed && !capped; p++) begin
        remain = npix;
        while (remain > 0 && !overflowed && !capped) begin
          pick = $urandom_range(0, 19);
          top  = (remain < 128) ? remain : 128;
          if (section_q.size() > tbl + BODY_CAP) begin
            capped = 1'b1;
          end else if (kind == SEC_OVERFLOW && remain < 128 && pick < 3) begin
            len = $urandom_range(remain + 1, 128);
            if (pick == 0 || len < 2) add(8'(len - 1));
            else add(8'(257 - len));
            overflowed = 1'b1;
          end else if (pick == 3) begin
            add(HDR_NOP);
          end else if (pick < 12 || remain < 2) begin
            len = $urandom_range(1, top);
            add(8'(len - 1));
            repeat (len) add(8'($urandom));
            remain -= len;
          end else begin
            len = $urandom_range(2, top);
            add(8'(257 - len));
            add(8'($urandom));
            remain -= len;
          end
        end
      end
      if (kind != SEC_EARLY) repeat ($urandom_range(0, 3)) add(8'($urandom));
      if (kind == SEC_EARLY && section_q.size() > 1) begin
        cut = $urandom_range(1, section_q.size() - 1);
        while (section_q.size() > cut) void'(section_q.pop_back());
      end
    end
    section_q[section_q.size() - 1].last = 1'b1;
  endtask

  task automatic run_phase(input int target);
    int start;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(0, 19);
      if (r < 12) gen_section(SEC_WELL);
      else if (r < 15) gen_section(SEC_EARLY);
      else if (r < 18) gen_section(SEC_OVERFLOW);
      else gen_section(SEC_NOISE);
      send_section();
    end
    settle();
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = REG_PIXEL_COUNT;
    cfg_data    = '0;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    end_of_data = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    idle_pct    = 20;
    cfg_pix     = 1;
    cfg_rows    = 1;
    cfg_ch      = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one pixel, one row, one plane
    add(8'h00); add(8'hFF); add(HDR_NOP); add(8'h00); add(8'hFF); add(8'h55, 1'b1);
    add(8'h00); add(8'hFF); add(8'hFF); add(8'h12, 1'b1);   // repeat past plane end
    add(8'h00, 1'b1);                                        // end inside the table
    add(8'hAA); add(8'h55); add(HDR_NOP, 1'b1);             // end on a no-op header
    send_section();
    settle();

    // no table, three planes: lanes 2, 1, 0 at four bytes per pixel
    set_config(3, 0, 3);
    add(8'hFE); add(8'hAA); add(8'h02); add(8'h01); add(8'h02); add(8'h03);
    add(8'h7F); add(8'h00, 1'b1);                            // literal past plane end
    add(8'hFE); add(8'h77, 1'b1);                            // end on a write
    send_section();
    settle();

    // register extremes
    write_reg(REG_UNUSED, '1);
    set_config(0, 0, 0);
    run_phase(30);
    idle_pct = 0;
    set_config(32'h1FF_FFFF, 32'h7FFF, 1);
    add(8'h00); add(8'h11); add(8'h22, 1'b1);               // end inside the table
    send_section();
    settle();
    set_config(32'h1FF_FFFF, 0, 1);
    add(8'h81); add(8'h5A); add(8'h01); add(8'h33); add(8'h44, 1'b1);
    send_section();
    settle();
    idle_pct = 20;
    set_config(1, 1, 4);
    run_phase(30);
    set_config(5, 2, 7);
    run_phase(30);

    for (int k = 0; k < 6; k++) begin
      idle_pct = (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 10 : 30);
      random_config();
      run_phase(40);
    end

    // output held off while input keeps coming
    idle_pct = 0;
    set_config(24, 1, 2);
    hold_req = 1'b1;
    run_phase(60);

    calm = 1'b1;
    random_config();
    run_phase(100);

    $display("covered %0d items, %0d writes checked, %0d register settings",
             items_sent, writes_seen, settings_used);
    $display("sections: %0d well-formed, %0d cut short, %0d overflowing, %0d noise",
             kind_count[SEC_WELL], kind_count[SEC_EARLY], kind_count[SEC_OVERFLOW],
             kind_count[SEC_NOISE]);
    if (fail_count == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
design/pkbd_pkg.sv
design/pkbd_front.sv
design/pkbd_back.sv
design/packbits_planar_image_decoder.sv
tb/sv/pkbd_write_checker.sv
tb/sv/tb_packbits_planar_image_decoder.sv
